[rtl/point_segment_distance_3d_unit_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the point to segment distance unit
// Clocked on clk, disabled while arst_n is low. Empty when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef POINT_SEGMENT_DISTANCE_3D_UNIT_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_3D_UNIT_DEFINES_SVH
`ifndef SYNTH
// property must hold at every clock edge out of reset
`define PSD_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("psd assertion failed");
// condition must never be true
`define PSD_NEVER(label, cond) \
	`PSD_ASSERT(label, !(cond))
`else
`define PSD_ASSERT(label, prop)
`define PSD_NEVER(label, cond)
`endif
`endif

[rtl/psd_pkg.sv]
// ---------------------------------------------------------------------------
// psd_pkg
// Shared types for the point to segment distance unit.
// ---------------------------------------------------------------------------
package psd_pkg;

	// which part of the segment lies nearest to the point
	typedef enum logic [1:0] {
		REGION_INTERIOR = 2'd0,
		REGION_A        = 2'd1,
		REGION_B        = 2'd2
	} region_t;

	localparam int REGION_WIDTH = 2;

endpackage

[rtl/point_segment_distance_3d_unit.sv]
// ---------------------------------------------------------------------------
// point_segment_distance_3d_unit
// Distance from a point to a 3D line segment, truncated, plus nearest region.
// ---------------------------------------------------------------------------
//  channel  handshake                   payload
//  item     item_valid / item_ready     a_x..a_z, b_x..b_z, p_x..p_z
//  result   result_valid / result_ready distance, nearest_region
//
// One item per cycle while the output register is not stalled. The pipe has
// 7 arithmetic stages, one divider stage per quotient bit, one square root
// stage per root bit. The last root stage is the output register.
// Whole pipe advances when the output register is empty or being taken.
// Reset clears the valid bits only.
// ---------------------------------------------------------------------------
`include "point_segment_distance_3d_unit_defines.svh"

module point_segment_distance_3d_unit import psd_pkg::*; #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic signed [COORD_WIDTH-1:0] a_x,
	input  logic signed [COORD_WIDTH-1:0] a_y,
	input  logic signed [COORD_WIDTH-1:0] a_z,
	input  logic signed [COORD_WIDTH-1:0] b_x,
	input  logic signed [COORD_WIDTH-1:0] b_y,
	input  logic signed [COORD_WIDTH-1:0] b_z,
	input  logic signed [COORD_WIDTH-1:0] p_x,
	input  logic signed [COORD_WIDTH-1:0] p_y,
	input  logic signed [COORD_WIDTH-1:0] p_z,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [COORD_WIDTH:0]          distance,
	output logic [1:0]                    nearest_region
);

	localparam int CW  = COORD_WIDTH;
	localparam int DW  = CW + 1;       // coordinate differences
	localparam int PW  = 2 * DW;       // signed products
	localparam int L2W = 2 * CW + 2;   // squared lengths, quotient
	localparam int TW  = 2 * CW + 3;   // dot product, cross components
	localparam int HW  = L2W / 2;      // half of a cross magnitude
	localparam int NW  = 2 * L2W;      // divider numerator
	localparam int RW  = L2W / 2;      // root width

	logic adv;
	assign adv        = !result_valid || result_ready;
	assign item_ready = adv;

	logic signed [CW-1:0] a_c [3];
	logic signed [CW-1:0] b_c [3];
	logic signed [CW-1:0] p_c [3];
	assign a_c = '{a_x, a_y, a_z};
	assign b_c = '{b_x, b_y, b_z};
	assign p_c = '{p_x, p_y, p_z};

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= item_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// stage 1: D = B - A, V = P - A, W = P - B
	logic signed [DW-1:0] d_s1 [3];
	logic signed [DW-1:0] v_s1 [3];
	logic signed [DW-1:0] w_s1 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				d_s1[k] <= DW'(b_c[k]) - DW'(a_c[k]);
				v_s1[k] <= DW'(p_c[k]) - DW'(a_c[k]);
				w_s1[k] <= DW'(p_c[k]) - DW'(b_c[k]);
			end
		end
	end

	// stage 2: all component products
	logic signed [PW-1:0] dv_s2 [3];
	logic signed [PW-1:0] dd_s2 [3];
	logic signed [PW-1:0] vv_s2 [3];
	logic signed [PW-1:0] ww_s2 [3];
	logic signed [PW-1:0] cp_s2 [3];
	logic signed [PW-1:0] cn_s2 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				dv_s2[k] <= d_s1[k] * v_s1[k];
				dd_s2[k] <= d_s1[k] * d_s1[k];
				vv_s2[k] <= v_s1[k] * v_s1[k];
				ww_s2[k] <= w_s1[k] * w_s1[k];
			end
			cp_s2[0] <= d_s1[1] * v_s1[2];
			cn_s2[0] <= d_s1[2] * v_s1[1];
			cp_s2[1] <= d_s1[2] * v_s1[0];
			cn_s2[1] <= d_s1[0] * v_s1[2];
			cp_s2[2] <= d_s1[0] * v_s1[1];
			cn_s2[2] <= d_s1[1] * v_s1[0];
		end
	end

	// stage 3: dot product, squared lengths, cross product
	logic signed [TW-1:0] t_s3;
	logic [L2W-1:0]       len2_s3;
	logic [L2W-1:0]       nv2_s3;
	logic [L2W-1:0]       nw2_s3;
	logic signed [TW-1:0] c_s3 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s3    <= TW'(dv_s2[0]) + TW'(dv_s2[1]) + TW'(dv_s2[2]);
			len2_s3 <= L2W'(dd_s2[0]) + L2W'(dd_s2[1]) + L2W'(dd_s2[2]);
			nv2_s3  <= L2W'(vv_s2[0]) + L2W'(vv_s2[1]) + L2W'(vv_s2[2]);
			nw2_s3  <= L2W'(ww_s2[0]) + L2W'(ww_s2[1]) + L2W'(ww_s2[2]);
			for (int k = 0; k < 3; k++) begin
				c_s3[k] <= TW'(cp_s2[k]) - TW'(cn_s2[k]);
			end
		end
	end

	// stage 4: pick region, cross magnitudes
	logic signed [TW-1:0] len2_ext;
	region_t              rg_nxt;
	logic [L2W-1:0]       d2e_nxt;

	assign len2_ext = $signed({1'b0, len2_s3});

	always_comb begin
		priority if (len2_s3 == '0 || t_s3 < 0) begin
			rg_nxt  = REGION_A;
			d2e_nxt = nv2_s3;
		end else if (t_s3 > len2_ext) begin
			rg_nxt  = REGION_B;
			d2e_nxt = nw2_s3;
		end else begin
			rg_nxt  = REGION_INTERIOR;
			d2e_nxt = nv2_s3;
		end
	end

	region_t        rg_s4;
	logic [L2W-1:0] d2e_s4;
	logic [L2W-1:0] len2_s4;
	logic [L2W-1:0] cm_s4 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			rg_s4   <= rg_nxt;
			d2e_s4  <= d2e_nxt;
			len2_s4 <= len2_s3;
			for (int k = 0; k < 3; k++) begin
				cm_s4[k] <= c_s3[k][TW-1] ? L2W'(-c_s3[k]) : L2W'(c_s3[k]);
			end
		end
	end

	// stage 5: partial products of the cross magnitude squares
	region_t        rg_s5;
	logic [L2W-1:0] d2e_s5;
	logic [L2W-1:0] len2_s5;
	logic [L2W-1:0] hh_s5 [3];
	logic [L2W-1:0] hl_s5 [3];
	logic [L2W-1:0] ll_s5 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			rg_s5   <= rg_s4;
			d2e_s5  <= d2e_s4;
			len2_s5 <= len2_s4;
			for (int k = 0; k < 3; k++) begin
				hh_s5[k] <= cm_s4[k][L2W-1:HW] * cm_s4[k][L2W-1:HW];
				hl_s5[k] <= cm_s4[k][L2W-1:HW] * cm_s4[k][HW-1:0];
				ll_s5[k] <= cm_s4[k][HW-1:0] * cm_s4[k][HW-1:0];
			end
		end
	end

	// stage 6: assemble each square
	region_t        rg_s6;
	logic [L2W-1:0] d2e_s6;
	logic [L2W-1:0] len2_s6;
	logic [NW-1:0]  sq_s6 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			rg_s6   <= rg_s5;
			d2e_s6  <= d2e_s5;
			len2_s6 <= len2_s5;
			for (int k = 0; k < 3; k++) begin
				sq_s6[k] <= (NW'(hh_s5[k]) << L2W) + (NW'(hl_s5[k]) << (HW + 1))
					+ NW'(ll_s5[k]);
			end
		end
	end

	// stage 7: divider operands; endpoint cases divide by one
	region_t        rg_s7;
	logic [NW-1:0]  num_s7;
	logic [L2W-1:0] den_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			rg_s7 <= rg_s6;
			if (rg_s6 == REGION_INTERIOR) begin
				num_s7 <= sq_s6[0] + sq_s6[1] + sq_s6[2];
				den_s7 <= len2_s6;
			end else begin
				num_s7 <= NW'(d2e_s6);
				den_s7 <= L2W'(1);
			end
		end
	end

	// squared distance
	logic                    dv_vld;
	logic [L2W-1:0]          dv_quo;
	logic [REGION_WIDTH-1:0] dv_tag;

	psd_div #(
		.QW (L2W),
		.TW (REGION_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (vld_s7),
		.in_num  (num_s7),
		.in_den  (den_s7),
		.in_tag  (rg_s7),
		.out_vld (dv_vld),
		.out_quo (dv_quo),
		.out_tag (dv_tag)
	);

	// distance; last stage drives the result port
	psd_sqrt #(
		.RW (RW),
		.TW (REGION_WIDTH)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (dv_vld),
		.in_x     (dv_quo),
		.in_tag   (dv_tag),
		.out_vld  (result_valid),
		.out_root (distance),
		.out_tag  (nearest_region)
	);

	// checks
	`PSD_NEVER(a_div_zero_den, vld_s7 && den_s7 == '0)
	`PSD_ASSERT(a_quo_fits, vld_s7 |-> (num_s7[NW-1:L2W] < den_s7))
	`PSD_NEVER(a_interior_degenerate, vld_s4 && rg_s4 == REGION_INTERIOR && len2_s4 == '0)

endmodule

[rtl/psd_div.sv]
// ---------------------------------------------------------------------------
// psd_div
// Pipelined restoring divider, one quotient bit per stage. The quotient must
// fit in QW bits (upper half of the numerator below the divisor).
// ---------------------------------------------------------------------------
module psd_div #(
	parameter int QW = 50,
	parameter int TW = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_vld,
	input  logic [2*QW-1:0] in_num,
	input  logic [QW-1:0]   in_den,
	input  logic [TW-1:0]   in_tag,
	output logic            out_vld,
	output logic [QW-1:0]   out_quo,
	output logic [TW-1:0]   out_tag
);

	logic            vld_s [1:QW];
	logic [QW-1:0]   rem_s [1:QW];
	logic [QW-1:0]   acc_s [1:QW];
	logic [QW-1:0]   den_s [1:QW];
	logic [TW-1:0]   tag_s [1:QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic          cur_vld;
		logic [QW-1:0] cur_rem;
		logic [QW-1:0] cur_acc;
		logic [QW-1:0] cur_den;
		logic [TW-1:0] cur_tag;
		logic [QW:0]   trial;
		logic [QW+1:0] dif;
		logic          ge;

		if (i == 0) begin : g_first
			assign cur_vld = in_vld;
			assign cur_rem = in_num[2*QW-1:QW];
			assign cur_acc = in_num[QW-1:0];
			assign cur_den = in_den;
			assign cur_tag = in_tag;
		end else begin : g_next
			assign cur_vld = vld_s[i];
			assign cur_rem = rem_s[i];
			assign cur_acc = acc_s[i];
			assign cur_den = den_s[i];
			assign cur_tag = tag_s[i];
		end

		// shift in the next numerator bit, subtract if it goes
		assign trial = {cur_rem, cur_acc[QW-1]};
		assign dif   = {1'b0, trial} - {2'b00, cur_den};
		assign ge    = !dif[QW+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				vld_s[i+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i+1] <= ge ? dif[QW-1:0] : trial[QW-1:0];
				acc_s[i+1] <= {cur_acc[QW-2:0], ge};
				den_s[i+1] <= cur_den;
				tag_s[i+1] <= cur_tag;
			end
		end
	end

	assign out_vld = vld_s[QW];
	assign out_quo = acc_s[QW];
	assign out_tag = tag_s[QW];

endmodule

[rtl/psd_sqrt.sv]
// ---------------------------------------------------------------------------
// psd_sqrt
// Pipelined integer square root, floor(sqrt(x)), one root bit per stage.
// ---------------------------------------------------------------------------
module psd_sqrt #(
	parameter int RW = 25,
	parameter int TW = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_vld,
	input  logic [2*RW-1:0] in_x,
	input  logic [TW-1:0]   in_tag,
	output logic            out_vld,
	output logic [RW-1:0]   out_root,
	output logic [TW-1:0]   out_tag
);

	logic            vld_s  [1:RW];
	logic [RW:0]     rem_s  [1:RW];
	logic [RW-1:0]   root_s [1:RW];
	logic [2*RW-1:0] xs_s   [1:RW];
	logic [TW-1:0]   tag_s  [1:RW];

	for (genvar i = 0; i < RW; i++) begin : g_stage
		logic            cur_vld;
		logic [RW:0]     cur_rem;
		logic [RW-1:0]   cur_root;
		logic [2*RW-1:0] cur_xs;
		logic [TW-1:0]   cur_tag;
		logic [RW+1:0]   r;
		logic [RW+1:0]   trial;
		logic [RW+2:0]   dif;
		logic            ge;

		if (i == 0) begin : g_first
			assign cur_vld  = in_vld;
			assign cur_rem  = '0;
			assign cur_root = '0;
			assign cur_xs   = in_x;
			assign cur_tag  = in_tag;
		end else begin : g_next
			assign cur_vld  = vld_s[i];
			assign cur_rem  = rem_s[i];
			assign cur_root = root_s[i];
			assign cur_xs   = xs_s[i];
			assign cur_tag  = tag_s[i];
		end

		// bring down two bits, try root*4+1
		assign r     = {cur_rem[RW-1:0], cur_xs[2*RW-1:2*RW-2]};
		assign trial = {cur_root, 2'b01};
		assign dif   = {1'b0, r} - {1'b0, trial};
		assign ge    = !dif[RW+2];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				vld_s[i+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i+1]  <= ge ? dif[RW:0] : r[RW:0];
				root_s[i+1] <= {cur_root[RW-2:0], ge};
				xs_s[i+1]   <= {cur_xs[2*RW-3:0], 2'b00};
				tag_s[i+1]  <= cur_tag;
			end
		end
	end

	assign out_vld  = vld_s[RW];
	assign out_root = root_s[RW];
	assign out_tag  = tag_s[RW];

endmodule

[test/point_segment_distance_3d_unit_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// point_segment_distance_3d_unit_checker
// Watches both channels, computes the expected distance and region for every
// accepted item, and compares each result transfer against the oldest one.
// ---------------------------------------------------------------------------
module point_segment_distance_3d_unit_checker import psd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_ready,
	input  logic signed [23:0] a_x,
	input  logic signed [23:0] a_y,
	input  logic signed [23:0] a_z,
	input  logic signed [23:0] b_x,
	input  logic signed [23:0] b_y,
	input  logic signed [23:0] b_z,
	input  logic signed [23:0] p_x,
	input  logic signed [23:0] p_y,
	input  logic signed [23:0] p_z,
	input  logic               result_valid,
	input  logic               result_ready,
	input  logic [24:0]        distance,
	input  logic [1:0]         nearest_region,
	output int                 fail_count,
	output int                 pending_count,
	output int                 result_count
);

	typedef struct packed {
		logic [24:0] dist_val;
		region_t     region;
	} seg_dist_t;

	seg_dist_t expected_q[$];

	// floor(sqrt(x)) by the bitwise method
	function automatic logic [63:0] int_sqrt(input logic [127:0] x);
		logic [127:0] root;
		logic [127:0] trial;
		root = 0;
		for (int i = 63; i >= 0; i--) begin
			trial = root | (128'd1 << i);
			if (trial * trial <= x)
				root = trial;
		end
		return root[63:0];
	endfunction

	function automatic seg_dist_t segment_distance(
		input logic signed [23:0] ax, ay, az, bx, by, bz, px, py, pz);
		logic signed [127:0] dx, dy, dz, vx, vy, vz, t, len2, cx, cy, cz, sq;
		seg_dist_t r;
		dx = bx - ax; dy = by - ay; dz = bz - az;
		vx = px - ax; vy = py - ay; vz = pz - az;
		t = dx * vx + dy * vy + dz * vz;
		len2 = dx * dx + dy * dy + dz * dz;
		if (len2 == 0 || t < 0) begin
			sq = vx * vx + vy * vy + vz * vz;
			r.region = REGION_A;
		end else if (t > len2) begin
			sq = (px - bx) * (px - bx) + (py - by) * (py - by) + (pz - bz) * (pz - bz);
			r.region = REGION_B;
		end else begin
			cx = dy * vz - dz * vy;
			cy = dz * vx - dx * vz;
			cz = dx * vy - dy * vx;
			sq = (cx * cx + cy * cy + cz * cz) / len2;
			r.region = REGION_INTERIOR;
		end
		r.dist_val = 25'(int_sqrt(sq));
		return r;
	endfunction

	// a mismatch is reported by one line and counted
	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		result_count = 0;
		pending_count = 0;
	end

	always @(posedge clk) begin
		seg_dist_t exp_r;
		if (arst_n) begin
			if (item_valid && item_ready)
				expected_q.push_back(segment_distance(a_x, a_y, a_z, b_x, b_y, b_z,
					p_x, p_y, p_z));
			if (result_valid && result_ready) begin
				result_count++;
				if (expected_q.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					exp_r = expected_q.pop_front();
					if (distance !== exp_r.dist_val)
						report_mismatch($sformatf("distance %0d, expected %0d",
							distance, exp_r.dist_val));
					if (nearest_region !== exp_r.region)
						report_mismatch($sformatf("region %0d, expected %0d",
							nearest_region, exp_r.region));
				end
			end
			pending_count = expected_q.size();
		end
	end

endmodule

[test/point_segment_distance_3d_unit_test.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// point_segment_distance_3d_unit_test
// Directed and random point/segment items with random idling on both sides
// and one long result hold-off; the checker predicts and compares.
// ---------------------------------------------------------------------------
module point_segment_distance_3d_unit_test import psd_pkg::*;;

	localparam int LATENCY     = 82;
	localparam int RANDOM_ITEMS = 440;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic signed [23:0] CMAX = 24'sh7FFFFF;
	localparam logic signed [23:0] CMIN = -24'sh800000;

	logic clk, arst_n;
	logic item_valid, item_ready, result_valid, result_ready;
	logic signed [23:0] a_x, a_y, a_z, b_x, b_y, b_z, p_x, p_y, p_z;
	logic [24:0] distance;
	logic [1:0]  nearest_region;
	int fail_count, pending_count, result_count;
	int cycle_count;
	bit quiet_tail, hold_off;

	point_segment_distance_3d_unit u_dut (.*);

	point_segment_distance_3d_unit_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
	end

	// random coordinate, sometimes an extreme or a small value
	function automatic logic signed [23:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return CMAX;
			1: return CMIN;
			2, 3: return $signed(24'($urandom_range(0, 1024))) - 24'sd512;
			default: return 24'($urandom);
		endcase
	endfunction

	// one transfer on the item channel, at times with a random gap before it
	task automatic send_item(input logic signed [23:0] ax, ay, az, bx, by, bz,
		px, py, pz);
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			item_valid <= 0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		item_valid <= 1;
		{a_x, a_y, a_z} <= {ax, ay, az};
		{b_x, b_y, b_z} <= {bx, by, bz};
		{p_x, p_y, p_z} <= {px, py, pz};
		do @(posedge clk); while (!item_ready);
	endtask

	// receiver: random stall bursts, one long hold-off, none in the tail
	initial begin
		result_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				result_ready <= 0;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
				result_ready <= 0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			result_ready <= 1;
		end
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		logic signed [23:0] ax, ay, az, bx, by, bz;
		item_valid = 0;
		{a_x, a_y, a_z, b_x, b_y, b_z, p_x, p_y, p_z} = '0;
		quiet_tail = 0;
		hold_off = 0;
		@(posedge arst_n);
		@(posedge clk);
		// directed: extremes, degenerate segment, each region, endpoint feet
		send_item(0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN);
		send_item(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
		send_item(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
		send_item(5, 5, 5, 5, 5, 5, 9, -3, 2);
		send_item(0, 0, 0, 24'sh10000, 0, 0, -24'sh10000, 24'sh10000, 0);
		send_item(0, 0, 0, 24'sh10000, 0, 0, 24'sh20000, 24'sh10000, 0);
		send_item(0, 0, 0, 24'sh10000, 0, 0, 24'sh8000, 24'sh10000, 7);
		send_item(0, 0, 0, 24'sh10000, 0, 0, 0, 24'sh10000, 24'sh10000);
		send_item(0, 0, 0, 24'sh10000, 0, 0, 24'sh10000, -24'sh30000, 3);
		send_item(CMAX, 0, CMIN, CMIN, 0, CMAX, 0, CMAX, 0);
		send_item(CMIN, CMAX, 0, CMAX, CMIN, 0, CMAX, CMAX, CMAX);
		send_item(-1, -1, -1, 1, 1, 1, 0, 0, 0);
		send_item(1, 2, 3, 4, 6, 8, 100, -50, 20);
		// long receiver hold-off while items keep coming
		hold_off = 1;
		repeat (150) send_item(rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), rand_coord());
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - 80)
				quiet_tail = 1;
			ax = rand_coord(); ay = rand_coord(); az = rand_coord();
			bx = rand_coord(); by = rand_coord(); bz = rand_coord();
			// occasionally a point exactly on an endpoint or a degenerate segment
			case ($urandom_range(0, 9))
				0: send_item(ax, ay, az, bx, by, bz, ax, ay, az);
				1: send_item(ax, ay, az, bx, by, bz, bx, by, bz);
				2: send_item(ax, ay, az, ax, ay, az, rand_coord(), rand_coord(),
					rand_coord());
				default: send_item(ax, ay, az, bx, by, bz, rand_coord(),
					rand_coord(), rand_coord());
			endcase
		end
		item_valid <= 0;
		while (pending_count != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("Covered %0d results: extreme coordinates, degenerate segments,", result_count);
		$display("all three regions, endpoint projections, stalls and a long hold-off.");
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
